// ===== rtl/plfwp_pkg.sv =====
// ----------------------------------------------------------------------------
// plfwp_pkg
// Types and constants shared by the synthesizer frequency-word programmer:
// payload structs, field widths, register base images and codes.
// ----------------------------------------------------------------------------
package plfwp_pkg;

    // Field widths
    localparam int FREQ_W  = 23;
    localparam int DIV_W   = 3;
    localparam int INT_W   = 16;
    localparam int FRAC_W  = 12;
    localparam int MOD_W   = 12;
    localparam int WORD_W  = 32;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 2;
    localparam int POWER_W = 2;

    // Loop constants
    localparam int PFD_KHZ      = 20000;
    localparam int FRAC_MODULUS = 4095;

    // Reciprocal division by the PFD frequency
    localparam int MAX_SHIFT   = 6;
    localparam int P_W         = FREQ_W + MAX_SHIFT;
    localparam int RECIP       = (2 ** P_W) / PFD_KHZ;
    localparam int RECIP_W     = $clog2(RECIP + 1);
    localparam int PROD_W      = P_W + RECIP_W;
    localparam int Q_W         = RECIP_W;
    localparam int D_W         = $clog2(PFD_KHZ + 1);
    localparam int QD_W        = Q_W + D_W;
    localparam int REM_W       = $clog2(PFD_KHZ);
    localparam int RAW_W       = REM_W + 1;
    localparam int NUM_W       = $clog2(FRAC_MODULUS + 1) + REM_W;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Operation codes
    localparam logic OP_PROGRAM = 1'b0;
    localparam logic OP_RESEND  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_W-1:0] CFG_AUX_OUTPUT_ENABLE  = 2'd0;
    localparam logic [CFG_W-1:0] CFG_OUTPUT_POWER_LEVEL = 2'd1;
    localparam logic [CFG_W-1:0] CFG_PRESCALER_SELECT   = 2'd2;

    // Output divider codes (divide by 2^code)
    localparam logic [DIV_W-1:0] DIV_BY_1  = 3'd0;
    localparam logic [DIV_W-1:0] DIV_BY_2  = 3'd1;
    localparam logic [DIV_W-1:0] DIV_BY_4  = 3'd2;
    localparam logic [DIV_W-1:0] DIV_BY_8  = 3'd3;
    localparam logic [DIV_W-1:0] DIV_BY_16 = 3'd4;
    localparam logic [DIV_W-1:0] DIV_BY_32 = 3'd5;
    localparam logic [DIV_W-1:0] DIV_BY_64 = 3'd6;

    // Synthesizer register indexes
    localparam logic [IDX_W-1:0] REG_IDX_0 = 3'd0;
    localparam logic [IDX_W-1:0] REG_IDX_1 = 3'd1;
    localparam logic [IDX_W-1:0] REG_IDX_2 = 3'd2;
    localparam logic [IDX_W-1:0] REG_IDX_3 = 3'd3;
    localparam logic [IDX_W-1:0] REG_IDX_4 = 3'd4;
    localparam logic [IDX_W-1:0] REG_IDX_5 = 3'd5;

    // Register base images
    localparam logic [WORD_W-1:0] REG5_BASE = 32'h0058_0005;
    localparam logic [WORD_W-1:0] REG4_BASE = 32'h008A_00E4;
    localparam logic [WORD_W-1:0] REG3_BASE = 32'h0000_04B3;
    localparam logic [WORD_W-1:0] REG2_BASE = 32'h0000_4E42;
    localparam logic [WORD_W-1:0] REG1_BASE = 32'h0000_8001;

    // Field positions
    localparam int DIV_POS   = 20;
    localparam int AUX_POS   = 8;
    localparam int POWER_POS = 3;
    localparam int PRESC_POS = 27;
    localparam int MOD_POS   = 3;
    localparam int INT_POS   = 15;
    localparam int FRAC_POS  = 3;

    // Reset values
    localparam logic [INT_W-1:0]   INT_RESET   = 16'd212;
    localparam logic [FRAC_W-1:0]  FRAC_RESET  = 12'd0;
    localparam logic [MOD_W-1:0]   MOD_INTEGER = 12'd2;
    localparam logic [DIV_W-1:0]   DIV_RESET   = DIV_BY_16;
    localparam logic [POWER_W-1:0] POWER_RESET = 2'd3;

    typedef struct packed {
        logic              operation;
        logic [FREQ_W-1:0] freq_khz;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] reg_word;
        logic [IDX_W-1:0]  reg_index;
        logic              last_word;
    } out_item_t;

    // Worked-out request held between front and back
    typedef struct packed {
        logic              operation;
        logic [DIV_W-1:0]  divider_code;
        logic [INT_W-1:0]  int_value;
        logic [FRAC_W-1:0] frac_value;
        logic [MOD_W-1:0]  modulus_value;
    } q_entry_t;

    // Pipeline tag carried alongside the arithmetic
    typedef struct packed {
        logic             operation;
        logic [DIV_W-1:0] divider_code;
    } tag_t;

endpackage

// ===== rtl/plfwp_front.sv =====
// ----------------------------------------------------------------------------
// plfwp_front
// Accepts requests, picks the output divider band and works out INT, FRAC
// and MOD through a free-running reciprocal-division pipeline.
// ----------------------------------------------------------------------------
module plfwp_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  plfwp_pkg::in_item_t in_data,
    input  logic               q_pop,
    output logic               q_push,
    output plfwp_pkg::q_entry_t q_wdata
);
    import plfwp_pkg::*;

    localparam logic [FREQ_W-1:0] BAND_MIN = 23'd35000;
    localparam logic [FREQ_W-1:0] BAND_MAX = 23'd4400000;
    localparam logic [FREQ_W-1:0] BAND_1   = 23'd2200000;
    localparam logic [FREQ_W-1:0] BAND_2   = 23'd1100000;
    localparam logic [FREQ_W-1:0] BAND_4   = 23'd550000;
    localparam logic [FREQ_W-1:0] BAND_8   = 23'd275000;
    localparam logic [FREQ_W-1:0] BAND_16  = 23'd137500;
    localparam logic [FREQ_W-1:0] BAND_32  = 23'd68750;

    logic                  accept;
    logic [DIV_W-1:0]      div_sel;
    logic [DIV_W-1:0]      div_track_reg;
    logic [QCNT_W-1:0]     occ_reg;
    logic [QCNT_W-1:0]     occ_next;

    // Pipeline valid bits, stages 0 to 7
    logic [7:0]            v_reg;

    logic [P_W-1:0]        p0_reg, p1_reg, p2_reg;
    tag_t                  tag0_reg, tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg,
                           tag6_reg;
    logic [PROD_W-1:0]     prod1_reg, prod5_reg;
    logic [Q_W-1:0]        q2_reg, q6_reg;
    logic [QD_W-1:0]       qd2_reg, qd6_reg;
    logic [INT_W-1:0]      int3_reg, int4_reg, int5_reg, int6_reg;
    logic [REM_W-1:0]      rem3_reg;
    logic [NUM_W-1:0]      num4_reg, num5_reg, num6_reg;
    q_entry_t              entry7_reg;

    logic [RAW_W-1:0]      raw1;
    logic [Q_W-1:0]        q1_fix;
    logic [REM_W-1:0]      rem1_fix;
    logic [RAW_W-1:0]      raw2;
    logic [Q_W-1:0]        q2_fix;
    q_entry_t              entry_next;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (occ_reg == QCNT_W'(QUEUE_DEPTH));

    // Octave band select; out-of-band keeps the previous divider
    always_comb
    begin
        div_sel = div_track_reg;
        if (in_data.freq_khz >= BAND_MIN && in_data.freq_khz <= BAND_MAX)
        begin
            if (in_data.freq_khz >= BAND_1)       div_sel = DIV_BY_1;
            else if (in_data.freq_khz >= BAND_2)  div_sel = DIV_BY_2;
            else if (in_data.freq_khz >= BAND_4)  div_sel = DIV_BY_4;
            else if (in_data.freq_khz >= BAND_8)  div_sel = DIV_BY_8;
            else if (in_data.freq_khz >= BAND_16) div_sel = DIV_BY_16;
            else if (in_data.freq_khz >= BAND_32) div_sel = DIV_BY_32;
            else                                  div_sel = DIV_BY_64;
        end
    end

    // Requests accepted but not yet popped by the back end
    always_comb
    begin
        occ_next = occ_reg;
        if (accept && !q_pop)
            occ_next = occ_reg + 1'b1;
        else if (!accept && q_pop)
            occ_next = occ_reg - 1'b1;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            div_track_reg <= DIV_RESET;
            v_reg         <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (accept && in_data.operation == OP_PROGRAM)
                div_track_reg <= div_sel;
            v_reg <= {v_reg[6:0], accept};
        end
    end

    // First quotient correction: estimate is exact or one low
    always_comb
    begin
        raw1     = RAW_W'(p2_reg - P_W'(qd2_reg));
        q1_fix   = q2_reg;
        rem1_fix = REM_W'(raw1);
        if (raw1 >= RAW_W'(PFD_KHZ))
        begin
            q1_fix   = q2_reg + 1'b1;
            rem1_fix = REM_W'(raw1 - RAW_W'(PFD_KHZ));
        end
    end

    // Second quotient correction and result packing
    always_comb
    begin
        raw2   = RAW_W'(P_W'(num6_reg) - P_W'(qd6_reg));
        q2_fix = q6_reg;
        if (raw2 >= RAW_W'(PFD_KHZ))
            q2_fix = q6_reg + 1'b1;
        entry_next.operation     = tag6_reg.operation;
        entry_next.divider_code  = tag6_reg.divider_code;
        entry_next.int_value     = int6_reg;
        entry_next.frac_value    = FRAC_W'(q2_fix);
        entry_next.modulus_value = (num6_reg == '0) ? MOD_INTEGER : MOD_W'(FRAC_MODULUS);
    end

    // Arithmetic pipeline datapath
    always_ff @(posedge clk)
    begin
        // stage 0: scaled frequency
        tag0_reg.operation    <= in_data.operation;
        tag0_reg.divider_code <= (in_data.operation == OP_PROGRAM) ? div_sel : div_track_reg;
        p0_reg <= P_W'(in_data.freq_khz) << div_sel;
        // stage 1: reciprocal product
        tag1_reg  <= tag0_reg;
        p1_reg    <= p0_reg;
        prod1_reg <= PROD_W'(p0_reg) * PROD_W'(RECIP);
        // stage 2: quotient estimate times divisor
        tag2_reg <= tag1_reg;
        p2_reg   <= p1_reg;
        q2_reg   <= Q_W'(prod1_reg >> P_W);
        qd2_reg  <= QD_W'(Q_W'(prod1_reg >> P_W)) * QD_W'(PFD_KHZ);
        // stage 3: INT and remainder
        tag3_reg <= tag2_reg;
        int3_reg <= INT_W'(q1_fix);
        rem3_reg <= rem1_fix;
        // stage 4: scaled remainder
        tag4_reg <= tag3_reg;
        int4_reg <= int3_reg;
        num4_reg <= NUM_W'(rem3_reg) * NUM_W'(FRAC_MODULUS);
        // stage 5: reciprocal product
        tag5_reg  <= tag4_reg;
        int5_reg  <= int4_reg;
        num5_reg  <= num4_reg;
        prod5_reg <= PROD_W'(num4_reg) * PROD_W'(RECIP);
        // stage 6: quotient estimate times divisor
        tag6_reg <= tag5_reg;
        int6_reg <= int5_reg;
        num6_reg <= num5_reg;
        q6_reg   <= Q_W'(prod5_reg >> P_W);
        qd6_reg  <= QD_W'(Q_W'(prod5_reg >> P_W)) * QD_W'(PFD_KHZ);
        // stage 7: finished entry
        entry7_reg <= entry_next;
    end

    assign q_push  = v_reg[7];
    assign q_wdata = entry7_reg;

    // Outstanding requests never exceed the queue room
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("front occupancy above queue depth");

endmodule

// ===== rtl/plfwp_queue.sv =====
// ----------------------------------------------------------------------------
// plfwp_queue
// Short FIFO of worked-out requests between the front and back ends, with a
// registered head entry presented to the back end.
// ----------------------------------------------------------------------------
module plfwp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  plfwp_pkg::q_entry_t wdata,
    input  logic                pop,
    output logic                rvalid,
    output plfwp_pkg::q_entry_t rdata
);
    import plfwp_pkg::*;

    q_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              head_valid_reg;
    logic              head_valid_next;
    q_entry_t          head_reg;
    logic              load;

    // Refill the head register when it is empty or being popped
    assign load = (count_reg != '0) && (!head_valid_reg || pop);

    // Entries held in storage
    always_comb
    begin
        count_next = count_reg;
        if (push && !load)
            count_next = count_reg + 1'b1;
        else if (!push && load)
            count_next = count_reg - 1'b1;
    end

    // Head entry occupancy
    always_comb
    begin
        head_valid_next = head_valid_reg;
        if (load)
            head_valid_next = 1'b1;
        else if (pop)
            head_valid_next = 1'b0;
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
            head_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            head_valid_reg <= head_valid_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (load)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    // Storage and registered read of the head
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
        if (load)
            head_reg <= mem_reg[rd_ptr_reg];
    end

    assign rvalid = head_valid_reg;
    assign rdata  = head_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !load |-> count_reg != QCNT_W'(QUEUE_DEPTH))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid_reg)
        else $error("queue popped while empty");

endmodule

// ===== rtl/plfwp_back.sv =====
// ----------------------------------------------------------------------------
// plfwp_back
// Holds the synthesizer state and configuration, and sends the six
// register words of each request from register 5 down to register 0.
// ----------------------------------------------------------------------------
module plfwp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  plfwp_pkg::q_entry_t           q_entry,
    output logic                          q_pop,
    input  logic                          cfg_write_en,
    input  logic [plfwp_pkg::CFG_W-1:0]   cfg_index,
    input  logic [plfwp_pkg::CFG_W-1:0]   cfg_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output plfwp_pkg::out_item_t          out_data
);
    import plfwp_pkg::*;

    logic                busy_reg, busy_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_data_reg, out_data_next;
    logic                advance;

    logic [INT_W-1:0]    int_reg;
    logic [FRAC_W-1:0]   frac_reg;
    logic [MOD_W-1:0]    mod_reg;
    logic [DIV_W-1:0]    div_reg;
    logic                aux_reg;
    logic [POWER_W-1:0]  power_reg;
    logic                presc_reg;
    logic [WORD_W-1:0]   word;

    // Output register frees up when empty or its transfer completes
    assign advance = !out_valid_reg || !out_stall;
    assign q_pop   = advance && !busy_reg && q_valid;

    // Register word for the current index
    always_comb
    begin
        case (idx_reg)
            REG_IDX_4: word = REG4_BASE | (WORD_W'(div_reg) << DIV_POS)
                              | (WORD_W'(aux_reg) << AUX_POS)
                              | (WORD_W'(power_reg) << POWER_POS);
            REG_IDX_3: word = REG3_BASE;
            REG_IDX_2: word = REG2_BASE;
            REG_IDX_1: word = REG1_BASE | (WORD_W'(presc_reg) << PRESC_POS)
                              | (WORD_W'(mod_reg) << MOD_POS);
            REG_IDX_0: word = (WORD_W'(int_reg) << INT_POS) | (WORD_W'(frac_reg) << FRAC_POS);
            default:   word = REG5_BASE;
        endcase
    end

    // Sequencer: pop starts a run with register 5, then 4 down to 0
    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (advance)
        begin
            if (busy_reg)
            begin
                out_valid_next          = 1'b1;
                out_data_next.reg_word  = word;
                out_data_next.reg_index = idx_reg;
                out_data_next.last_word = (idx_reg == REG_IDX_0);
                if (idx_reg == REG_IDX_0)
                    busy_next = 1'b0;
                else
                    idx_next = idx_reg - 1'b1;
            end
            else if (q_valid)
            begin
                out_valid_next          = 1'b1;
                out_data_next.reg_word  = REG5_BASE;
                out_data_next.reg_index = REG_IDX_5;
                out_data_next.last_word = 1'b0;
                busy_next               = 1'b1;
                idx_next                = REG_IDX_4;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    // Control state, synthesizer state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= REG_IDX_5;
            out_valid_reg <= 1'b0;
            int_reg       <= INT_RESET;
            frac_reg      <= FRAC_RESET;
            mod_reg       <= MOD_INTEGER;
            div_reg       <= DIV_RESET;
            aux_reg       <= 1'b1;
            power_reg     <= POWER_RESET;
            presc_reg     <= 1'b1;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (q_pop && q_entry.operation == OP_PROGRAM)
            begin
                int_reg  <= q_entry.int_value;
                frac_reg <= q_entry.frac_value;
                mod_reg  <= q_entry.modulus_value;
                div_reg  <= q_entry.divider_code;
            end
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_AUX_OUTPUT_ENABLE:  aux_reg   <= cfg_data[0];
                    CFG_OUTPUT_POWER_LEVEL: power_reg <= cfg_data;
                    CFG_PRESCALER_SELECT:   presc_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Words of one run leave back to back
    a_run_continuous: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.last_word |=> out_valid)
        else $error("gap inside a register word run");

endmodule

// ===== rtl/pll_frequency_word_programmer_unit.sv =====
// ----------------------------------------------------------------------------
// pll_frequency_word_programmer_unit
// Turns a target frequency in kHz into the six synthesizer register words.
//
// Input channel (in_valid / in_stall / in_data): operation 0 programs a new
// frequency, operation 1 resends the current words. A transfer happens when
// in_valid is high and in_stall is low.
// Output channel (out_valid / out_stall / out_data): six transfers per
// request, registers 5 down to 0, last_word set on register 0.
// Configuration: cfg_write_en with cfg_index 0 (aux output enable),
// 1 (output power level) or 2 (prescaler select); write only when idle.
// Register 5 is presented once the request has passed the eight-stage
// reciprocal-division pipeline, the queue and its head. Throughput: one
// output word per cycle while out_stall is low; the word sequencer takes a
// new request after the last word of the one before, with up to 4 buffered.
// Reset: state returns to INT 212, FRAC 0, MOD 2, divide by 16, aux on,
// +5 dBm, 8/9 prescaler; nothing is sent until a request arrives.
// A stalled receiver holds the current word; the front keeps accepting
// until the buffer is full, then raises in_stall.
// ----------------------------------------------------------------------------
module pll_frequency_word_programmer_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  plfwp_pkg::in_item_t          in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output plfwp_pkg::out_item_t         out_data,
    input  logic                         cfg_write_en,
    input  logic [plfwp_pkg::CFG_W-1:0]  cfg_index,
    input  logic [plfwp_pkg::CFG_W-1:0]  cfg_data
);
    import plfwp_pkg::*;

    logic     q_push;
    logic     q_pop;
    logic     q_valid;
    q_entry_t q_wdata;
    q_entry_t q_rdata;

    // Classification and arithmetic
    plfwp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_pop    (q_pop),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    // Request buffer
    plfwp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rvalid (q_valid),
        .rdata  (q_rdata)
    );

    // Word sequencer
    plfwp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_entry      (q_rdata),
        .q_pop        (q_pop),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data)
    );

endmodule
